### hdl/sorted_rect_table_unit_macros.svh
// Assertion macros shared by the checker of the sorted rectangle table.
// Depends on nothing; each macro expands to one clocked concurrent assertion.
`ifndef SORTED_RECT_TABLE_UNIT_MACROS_SVH
`define SORTED_RECT_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SRT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/srt_pkg.sv
// Types and constants of the sorted rectangle table.
// Used by sorted_rect_table_unit, srt_checker and the testbench; depends on nothing.
`default_nettype none

package srt_pkg;

  localparam int unsigned S_DATA_W = 128;
  localparam int unsigned S_USER_W = 3;
  localparam int unsigned M_DATA_W = 136;
  localparam int unsigned M_USER_W = 2;
  localparam int unsigned CNT_W    = 5;

  typedef enum logic [2:0] {
    ACT_INSERT    = 3'd0,
    ACT_REMOVE    = 3'd1,
    ACT_GET_FIRST = 3'd2,
    ACT_GET_NEXT  = 3'd3,
    ACT_CLEAR     = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_RM,
    ST_GET,
    ST_DONE
  } state_t;

  // Packed so that the left edge sits in the lowest bits.
  typedef struct packed {
    logic signed [31:0] bottom;
    logic signed [31:0] right;
    logic signed [31:0] top;
    logic signed [31:0] left;
  } entry_t;

  typedef struct packed {
    logic              insert_dropped;
    logic              entry_valid;
    logic [CNT_W-1:0]  removed_count;
    entry_t            ent;
  } result_t;

endpackage

`default_nettype wire

### hdl/sorted_rect_table_unit.sv
// Sorted rectangle table: holds up to DEPTH rectangles in ascending order of
// the right edge, in a ring buffer in one RAM, walked by a sequencer with a
// single signed comparator. One word is taken at a time. An insert walks back
// from the tail and moves each entry with a right edge not below the new one
// back one slot; a remove-before examines entries from the head; get-first and
// get-next read one entry on a hit; clear empties the table. The walks do one
// RAM read and one compare per cycle. The result word is held in an output
// register. The next word can be taken while that result waits, and the new
// result is held back until the output register is free. No clearing pass is
// needed after reset.
// Depends on srt_pkg, srt_ram and srt_cmp.
`default_nettype none

module sorted_rect_table_unit #(
  parameter int DEPTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // in_left, in_top, in_right, in_bottom
  input  wire logic [srt_pkg::S_DATA_W-1:0]   s_tdata,
  // action
  input  wire logic [srt_pkg::S_USER_W-1:0]   s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // out_left, out_top, out_right, out_bottom, removed_count, zero fill
  output logic      [srt_pkg::M_DATA_W-1:0]   m_tdata,
  // entry_valid, insert_dropped
  output logic      [srt_pkg::M_USER_W-1:0]   m_tuser
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = $bits(srt_pkg::entry_t);

  srt_pkg::state_t  state, state_next;
  logic [AW-1:0]    head, head_next;
  logic [CW-1:0]    count, count_next;
  logic [CW-1:0]    cursor, cursor_next;
  logic             cur_on, cur_on_next;
  logic [CW-1:0]    idx, idx_next;
  srt_pkg::entry_t  in_ent;
  srt_pkg::result_t res, res_next;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [EW-1:0]    ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [EW-1:0]    ram_rdata;
  srt_pkg::entry_t  rd_ent;
  logic signed [31:0] cmp_b;
  logic             lt;
  logic [CW-1:0]    cur_inc;
  logic [CW-1:0]    idx_inc;
  logic             out_free;

  // Logical position to RAM address; one wrap, exact for offsets up to DEPTH.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] ofs);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(ofs);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  srt_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_ent = srt_pkg::entry_t'(ram_rdata);
  assign cmp_b  = (state == srt_pkg::ST_RM) ? in_ent.left : in_ent.right;

  srt_cmp u_cmp (
    .a  (rd_ent.right),
    .b  (cmp_b),
    .lt (lt)
  );

  assign s_tready = (state == srt_pkg::ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign cur_inc  = cursor + CW'(1);
  assign idx_inc  = idx + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= srt_pkg::ST_IDLE;
      head   <= '0;
      count  <= '0;
      cursor <= '0;
      cur_on <= 1'b0;
      idx    <= '0;
    end else begin
      state  <= state_next;
      head   <= head_next;
      count  <= count_next;
      cursor <= cursor_next;
      cur_on <= cur_on_next;
      idx    <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_ent <= srt_pkg::entry_t'(s_tdata);
    end
    res <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == srt_pkg::ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == srt_pkg::ST_DONE && out_free) begin
      m_tdata <= {(srt_pkg::M_DATA_W - EW - srt_pkg::CNT_W)'(0),
                  res.removed_count, res.ent};
      m_tuser <= {res.insert_dropped, res.entry_valid};
    end
  end

  always_comb begin
    state_next  = state;
    head_next   = head;
    count_next  = count;
    cursor_next = cursor;
    cur_on_next = cur_on;
    idx_next    = idx;
    res_next    = res;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = ram_rdata;
    ram_raddr   = '0;

    case (state)
      srt_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          res_next   = '0;
          state_next = srt_pkg::ST_DONE;
          case (s_tuser)
            srt_pkg::ACT_INSERT: begin
              cur_on_next = 1'b0;
              if (count >= CW'(DEPTH)) begin
                res_next.insert_dropped = 1'b1;
              end else begin
                // Walk back from the tail; the read is ignored on an empty table.
                idx_next   = count;
                ram_raddr  = phys(head, count - CW'(1));
                state_next = srt_pkg::ST_INS;
              end
            end
            srt_pkg::ACT_REMOVE: begin
              cur_on_next = 1'b0;
              idx_next    = '0;
              if (count != '0) begin
                ram_raddr  = phys(head, '0);
                state_next = srt_pkg::ST_RM;
              end
            end
            srt_pkg::ACT_GET_FIRST: begin
              if (count != '0) begin
                cursor_next = '0;
                cur_on_next = 1'b1;
                ram_raddr   = phys(head, '0);
                state_next  = srt_pkg::ST_GET;
              end else begin
                cur_on_next = 1'b0;
              end
            end
            srt_pkg::ACT_GET_NEXT: begin
              if (cur_on) begin
                if (cur_inc < count) begin
                  cursor_next = cur_inc;
                  ram_raddr   = phys(head, cur_inc);
                  state_next  = srt_pkg::ST_GET;
                end else begin
                  cur_on_next = 1'b0;
                end
              end
            end
            srt_pkg::ACT_CLEAR: begin
              count_next  = '0;
              cur_on_next = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      srt_pkg::ST_INS: begin
        // rd_ent holds the entry just ahead of slot idx.
        if (idx != '0 && !lt) begin
          ram_we    = 1'b1;
          ram_waddr = phys(head, idx);
          ram_wdata = ram_rdata;
          idx_next  = idx - CW'(1);
          ram_raddr = phys(head, idx - CW'(2));
        end else begin
          ram_we     = 1'b1;
          ram_waddr  = phys(head, idx);
          ram_wdata  = in_ent;
          count_next = count + CW'(1);
          state_next = srt_pkg::ST_DONE;
        end
      end

      srt_pkg::ST_RM: begin
        if (lt && idx_inc < count) begin
          idx_next  = idx_inc;
          ram_raddr = phys(head, idx_inc);
        end else if (lt) begin
          head_next              = phys(head, idx_inc);
          count_next             = count - idx_inc;
          res_next.removed_count = srt_pkg::CNT_W'(idx_inc);
          state_next             = srt_pkg::ST_DONE;
        end else begin
          head_next              = phys(head, idx);
          count_next             = count - idx;
          res_next.removed_count = srt_pkg::CNT_W'(idx);
          state_next             = srt_pkg::ST_DONE;
        end
      end

      srt_pkg::ST_GET: begin
        res_next.ent         = rd_ent;
        res_next.entry_valid = 1'b1;
        state_next           = srt_pkg::ST_DONE;
      end

      srt_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = srt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = srt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/srt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module srt_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/srt_cmp.sv
// Shared signed 32-bit less-than comparator used by insert and remove walks.
// Depends on nothing.
`default_nettype none

module srt_cmp (
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic                    lt
);

  assign lt = (a < b);

endmodule

`default_nettype wire

### hdl/srt_checker.sv
// Port-level checker for the sorted rectangle table, bound to the top level.
// Depends on srt_pkg and the assertion macros header.
`default_nettype none
`include "sorted_rect_table_unit_macros.svh"

module srt_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_tvalid,
  input wire logic                         s_tready,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [srt_pkg::M_DATA_W-1:0] m_tdata,
  input wire logic [srt_pkg::M_USER_W-1:0] m_tuser
);

  // A result never both returns an entry and reports a dropped insert.
  `SRT_ASSERT_IMP(a_flags_excl, clk, rst, m_tvalid, !(m_tuser[0] && m_tuser[1]), "entry and drop both set")

  // A removal count only comes with neither flag set.
  `SRT_ASSERT_IMP(a_rm_alone, clk, rst, m_tvalid && (m_tdata[132:128] != 5'd0), m_tuser == 2'b00, "count with flags")

  // Without a returned entry the edge fields read zero.
  `SRT_ASSERT_IMP(a_zero_edges, clk, rst, m_tvalid && !m_tuser[0], m_tdata[127:0] == 128'd0, "stale edges")

  // One word is worked on at a time.
  `SRT_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready, "accepted twice in a row")

  // A result held back by the consumer stays offered.
  `SRT_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid, "result withdrawn")

endmodule

bind sorted_rect_table_unit srt_checker u_srt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

### tb/tb_sorted_rect_table_unit.sv
// Testbench for sorted_rect_table_unit: drives action words with random gaps and stalls,
// predicts each result word in a shadow of the table and checks the outputs field by field.
// Depends on srt_pkg and the RTL of the block only.
`default_nettype none

module tb_sorted_rect_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 16;
  localparam int IDLE_PCT = 23;
  localparam int RANDOM_WORDS = 600;
  localparam int HOLD_AT = 250;
  localparam int HOLD_CYCLES = 300;
  localparam int STEADY_FROM = 400;
  localparam int STEADY_TO = 480;
  localparam int QUIET_LIMIT = 4000;
  localparam int REPORT_MAX = 10;
  localparam logic [2:0] SPARE_LO = 3'd5;
  localparam logic [2:0] SPARE_HI = 3'd7;
  localparam logic signed [31:0] EDGE_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] EDGE_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic [31:0] left;
    logic [31:0] top;
    logic [31:0] right;
    logic [31:0] bottom;
    logic        valid;
    logic [4:0]  removed;
    logic        dropped;
  } rect_result_t;

  // Shadow copy of the table; works out the result word of every accepted action word.
  class rect_table_shadow;
    logic signed [31:0] lefts [TABLE_DEPTH];
    logic signed [31:0] tops [TABLE_DEPTH];
    logic signed [31:0] rights [TABLE_DEPTH];
    logic signed [31:0] bottoms [TABLE_DEPTH];
    int count = 0;
    int cursor = 0;
    bit cursor_on = 0;
    rect_result_t pending_results[$];
    int mismatches = 0;
    int words = 0;
    int drops = 0;
    int hits = 0;
    int removed_total = 0;

    function void read_entry(int idx, ref rect_result_t res);
      res.left = lefts[idx];
      res.top = tops[idx];
      res.right = rights[idx];
      res.bottom = bottoms[idx];
      res.valid = 1'b1;
      hits++;
    endfunction

    function void note_word(logic [2:0] act, logic signed [31:0] l, logic signed [31:0] t,
                            logic signed [31:0] r, logic signed [31:0] b);
      rect_result_t res;
      int pos;
      res = '{default: '0};
      words++;
      case (act)
        srt_pkg::ACT_INSERT: begin
          cursor_on = 0;
          if (count >= TABLE_DEPTH) begin
            res.dropped = 1'b1;
            drops++;
          end else begin
            pos = 0;
            while (pos < count && rights[pos] < r) pos++;
            for (int i = count; i > pos; i--) begin
              lefts[i] = lefts[i-1];
              tops[i] = tops[i-1];
              rights[i] = rights[i-1];
              bottoms[i] = bottoms[i-1];
            end
            lefts[pos] = l;
            tops[pos] = t;
            rights[pos] = r;
            bottoms[pos] = b;
            count++;
          end
        end
        srt_pkg::ACT_REMOVE: begin
          cursor_on = 0;
          pos = 0;
          while (pos < count && rights[pos] < l) pos++;
          for (int i = pos; i < count; i++) begin
            lefts[i-pos] = lefts[i];
            tops[i-pos] = tops[i];
            rights[i-pos] = rights[i];
            bottoms[i-pos] = bottoms[i];
          end
          count -= pos;
          res.removed = pos[4:0];
          removed_total += pos;
        end
        srt_pkg::ACT_GET_FIRST: begin
          if (count > 0) begin
            cursor = 0;
            cursor_on = 1;
            read_entry(0, res);
          end else begin
            cursor_on = 0;
          end
        end
        srt_pkg::ACT_GET_NEXT: begin
          if (cursor_on) begin
            cursor++;
            if (cursor < count) read_entry(cursor, res);
            else cursor_on = 0;
          end
        end
        srt_pkg::ACT_CLEAR: begin
          count = 0;
          cursor_on = 0;
        end
        default: ;
      endcase
      pending_results.push_back(res);
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("mismatch on %s: expected %h, got %h", what, want, got);
    endfunction

    function void check_word(logic [srt_pkg::M_DATA_W-1:0] data,
                             logic [srt_pkg::M_USER_W-1:0] user);
      rect_result_t want;
      if (pending_results.size() == 0) begin
        report("unexpected result word", '0, data[31:0]);
        return;
      end
      want = pending_results.pop_front();
      if (data[31:0] !== want.left) report("out_left", want.left, data[31:0]);
      if (data[63:32] !== want.top) report("out_top", want.top, data[63:32]);
      if (data[95:64] !== want.right) report("out_right", want.right, data[95:64]);
      if (data[127:96] !== want.bottom) report("out_bottom", want.bottom, data[127:96]);
      if (data[132:128] !== want.removed)
        report("removed_count", 32'(want.removed), 32'(data[132:128]));
      if (user[0] !== want.valid) report("entry_valid", 32'(want.valid), 32'(user[0]));
      if (user[1] !== want.dropped) report("insert_dropped", 32'(want.dropped), 32'(user[1]));
    endfunction
  endclass

  logic                         clk;
  logic                         rst;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [srt_pkg::S_DATA_W-1:0] s_tdata;
  logic [srt_pkg::S_USER_W-1:0] s_tuser;
  logic                         m_tvalid;
  logic                         m_tready;
  logic [srt_pkg::M_DATA_W-1:0] m_tdata;
  logic [srt_pkg::M_USER_W-1:0] m_tuser;

  rect_table_shadow shadow = new();
  int words_sent = 0;
  bit steady;

  assign steady = (words_sent >= STEADY_FROM) && (words_sent < STEADY_TO);

  sorted_rect_table_unit #(.DEPTH(TABLE_DEPTH)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Both handshakes are sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      shadow.note_word(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[95:64],
                       s_tdata[127:96]);
      words_sent <= words_sent + 1;
    end
    if (!rst && m_tvalid && m_tready) shadow.check_word(m_tdata, m_tuser);
  end

  // Result side: random stalls, one long hold-off so that the block backs up
  // into its input, and a stretch where it always takes the word.
  initial begin : result_sink
    bit held;
    held = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && words_sent >= HOLD_AT) begin
        held = 1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
    $display("** sorted_rect_table_unit: FAILED **");
    $finish;
  end

  // Called and returning at a falling edge.
  task automatic send_word(input logic [2:0] act, input logic signed [31:0] l,
                           input logic signed [31:0] t, input logic signed [31:0] r,
                           input logic signed [31:0] b);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {b, r, t, l};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Half the keys fall in a narrow band so that equal keys and partial removals are common.
  function automatic logic signed [31:0] pick_key();
    if ($urandom_range(0, 1)) return 32'(int'($urandom_range(0, 40)) - 20);
    return $urandom;
  endfunction

  initial begin : stimulus
    int roll;
    logic [2:0] act;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Reads from an empty table, an unused action code, then extreme edges
    // and two equal keys, walked with the cursor up to and past the end.
    send_word(srt_pkg::ACT_GET_FIRST, 0, 0, 0, 0);
    send_word(srt_pkg::ACT_GET_NEXT, 0, 0, 0, 0);
    send_word(SPARE_HI, -1, -1, -1, -1);
    send_word(srt_pkg::ACT_INSERT, EDGE_MIN, EDGE_MAX, EDGE_MAX, EDGE_MIN);
    send_word(srt_pkg::ACT_INSERT, EDGE_MAX, EDGE_MIN, EDGE_MIN, EDGE_MAX);
    send_word(srt_pkg::ACT_INSERT, 1, 2, 0, 3);
    send_word(srt_pkg::ACT_INSERT, 4, 5, 0, 6);
    send_word(srt_pkg::ACT_GET_FIRST, 0, 0, 0, 0);
    repeat (5) send_word(srt_pkg::ACT_GET_NEXT, 0, 0, 0, 0);
    send_word(srt_pkg::ACT_REMOVE, EDGE_MIN, 0, 0, 0);
    send_word(srt_pkg::ACT_GET_NEXT, 0, 0, 0, 0);
    send_word(srt_pkg::ACT_CLEAR, 0, 0, 0, 0);
    // Fill the table, overflow it once, then remove every entry below EDGE_MAX at once.
    repeat (TABLE_DEPTH)
      send_word(srt_pkg::ACT_INSERT, $urandom, $urandom, pick_key(), $urandom);
    send_word(srt_pkg::ACT_INSERT, 7, 8, 9, 10);
    send_word(srt_pkg::ACT_REMOVE, EDGE_MAX, 0, 0, 0);

    repeat (RANDOM_WORDS) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) act = srt_pkg::ACT_INSERT;
      else if (roll < 52) act = srt_pkg::ACT_REMOVE;
      else if (roll < 64) act = srt_pkg::ACT_GET_FIRST;
      else if (roll < 91) act = srt_pkg::ACT_GET_NEXT;
      else if (roll < 96) act = srt_pkg::ACT_CLEAR;
      else act = 3'($urandom_range(SPARE_LO, SPARE_HI));
      send_word(act, (act == srt_pkg::ACT_REMOVE) ? pick_key() : $urandom, $urandom,
                pick_key(), $urandom);
    end
    s_tvalid <= 1'b0;

    while (shadow.pending_results.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);

    $display("covered %0d action words: %0d entries read back, %0d removed",
             shadow.words, shadow.hits, shadow.removed_total);
    $display("dropped on a full table: %0d; mismatches: %0d", shadow.drops,
             shadow.mismatches);
    if (shadow.mismatches == 0) begin
      $display("** sorted_rect_table_unit: PASSED **");
    end else begin
      $display("** sorted_rect_table_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
